[rtl/core/fbsc_pkg.sv]
// shared types and constants for the frustum box sphere surface cull core
package fbsc_pkg;

  localparam int COORD_W         = 24;
  localparam int NORMAL_W        = 18;
  localparam int PROD_W          = NORMAL_W + COORD_W;
  localparam int DOT_W           = PROD_W + 2;
  localparam int THR_W           = COORD_W + 1;
  localparam int Q_SHIFT         = 16;
  localparam int FRUSTUM_PLANES  = 4;
  localparam int SURF_SLOT       = FRUSTUM_PLANES;
  localparam int NUM_SLOTS       = FRUSTUM_PLANES + 1;
  localparam int AXIS_COUNT      = 3;
  localparam int BACKFACE_MARGIN = 3;
  localparam int SLOT_W          = 3;
  localparam int MASK_W          = 4;
  localparam int CODE_W          = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = 1;
  localparam int QCNT_W          = 2;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BOX    = 2'd1,
    OP_SPHERE = 2'd2,
    OP_SURF   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_CULL_DISABLE = 2'd0,
    REG_EYE_X        = 2'd1,
    REG_EYE_Y        = 2'd2,
    REG_EYE_Z        = 2'd3
  } reg_idx_t;

  // what the back end has to do with a transaction
  typedef enum logic [2:0] {
    K_LOAD,
    K_PASS,
    K_BOX,
    K_SPHERE,
    K_SURF
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord3_t;

  typedef struct packed {
    kind_t                     kind;
    logic [SLOT_W-1:0]         slot;
    logic [MASK_W-1:0]         mask;
    logic [CODE_W-1:0]         code;
    logic                      back;
    coord3_t                   a;
    coord3_t                   b;
    logic signed [COORD_W-1:0] scalar;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [MASK_W-1:0] mask;
    logic              back;
  } ctl_t;

  typedef struct packed {
    logic    cull_disable;
    coord3_t eye;
  } cfg_t;

endpackage

[rtl/core/fbsc_front.sv]
// front end: accepts input transactions and classifies them for the back end
module fbsc_front import fbsc_pkg::*; (
  input  logic                      cull_disable,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic [MASK_W-1:0]         in_clip_mask,
  input  logic [CODE_W-1:0]         in_plane_code,
  input  logic                      in_back_side,
  input  logic signed [COORD_W-1:0] in_a_x,
  input  logic signed [COORD_W-1:0] in_a_y,
  input  logic signed [COORD_W-1:0] in_a_z,
  input  logic signed [COORD_W-1:0] in_b_x,
  input  logic signed [COORD_W-1:0] in_b_y,
  input  logic signed [COORD_W-1:0] in_b_z,
  input  logic signed [COORD_W-1:0] in_scalar,
  input  logic                      q_full,
  output logic                      push,
  output item_t                     push_item
);

  kind_t kind;

  always_comb begin
    unique case (op_t'(in_op))
      OP_LOAD:   kind = K_LOAD;
      OP_BOX:    kind = K_BOX;
      OP_SPHERE: kind = K_SPHERE;
      OP_SURF:   kind = K_SURF;
      default:   kind = K_LOAD;
    endcase
    // disabled culling answers zero for every test
    if (cull_disable && kind != K_LOAD) begin
      kind = K_PASS;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign push_item.kind   = kind;
  assign push_item.slot   = in_slot;
  assign push_item.mask   = in_clip_mask;
  assign push_item.code   = in_plane_code;
  assign push_item.back   = in_back_side;
  assign push_item.a.x    = in_a_x;
  assign push_item.a.y    = in_a_y;
  assign push_item.a.z    = in_a_z;
  assign push_item.b.x    = in_b_x;
  assign push_item.b.y    = in_b_y;
  assign push_item.b.z    = in_b_z;
  assign push_item.scalar = in_scalar;

endmodule

[rtl/core/fbsc_queue.sv]
// short queue between the front end and the back end
module fbsc_queue import fbsc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t head_item
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == QCNT_W'(QUEUE_DEPTH);
  assign q_valid   = count_r != '0;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/fbsc_back.sv]
// back end: plane bank, per-plane dot product lanes and the result register
module fbsc_back import fbsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  coord3_t eye,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output logic    out_culled
);

  // plane bank
  logic signed [NORMAL_W-1:0] normal_r [NUM_SLOTS][3];
  logic signed [COORD_W-1:0]  dist_r   [NUM_SLOTS];
  logic [CODE_W-1:0]          code_r   [NUM_SLOTS];

  // stage 1: products and thresholds
  logic                     s1_valid_r;
  ctl_t                     s1_ctl_r;
  logic signed [PROD_W-1:0] s1_prod_r [NUM_SLOTS][3];
  logic signed [PROD_W-1:0] s1_prod_nxt [NUM_SLOTS][3];
  logic signed [THR_W-1:0]  s1_base_r [NUM_SLOTS];
  logic signed [THR_W-1:0]  s1_base_nxt [NUM_SLOTS];

  // stage 2: dot products
  logic                     s2_valid_r;
  ctl_t                     s2_ctl_r;
  logic signed [DOT_W-1:0]  s2_dot_r [NUM_SLOTS];
  logic signed [DOT_W-1:0]  s2_dot_nxt [NUM_SLOTS];
  logic signed [THR_W-1:0]  s2_base_r [NUM_SLOTS];

  // result register
  logic out_valid_r, out_valid_nxt;
  logic out_culled_r, out_culled_nxt;

  logic adv;
  logic is_sph;
  logic general;
  logic [CODE_W-1:0] surf_type;
  logic signed [COORD_W-1:0] pt [FRUSTUM_PLANES][3];
  logic signed [COORD_W-1:0] eye_v [3];
  logic signed [DOT_W-1:0]   thr [NUM_SLOTS];
  logic [FRUSTUM_PLANES-1:0] hit;
  logic                      surf_hit;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && q_valid;

  assign eye_v[0] = eye.x;
  assign eye_v[1] = eye.y;
  assign eye_v[2] = eye.z;

  always_comb begin
    is_sph    = q_item.kind == K_SPHERE;
    surf_type = code_r[SURF_SLOT];
    general   = surf_type >= CODE_W'(AXIS_COUNT);
    for (int i = 0; i < FRUSTUM_PLANES; i++) begin
      // sign bits pick the min corner, a sphere uses its center
      pt[i][0] = (is_sph || code_r[i][0]) ? q_item.a.x : q_item.b.x;
      pt[i][1] = (is_sph || code_r[i][1]) ? q_item.a.y : q_item.b.y;
      pt[i][2] = (is_sph || code_r[i][2]) ? q_item.a.z : q_item.b.z;
      for (int k = 0; k < 3; k++) begin
        s1_prod_nxt[i][k] = PROD_W'(normal_r[i][k]) * PROD_W'(pt[i][k]);
      end
      s1_base_nxt[i] = is_sph ? THR_W'(dist_r[i]) - THR_W'(q_item.scalar)
                              : THR_W'(dist_r[i]);
    end
    // surface plane: normal times eye; if axial, eye scaled to the dot's fixed point
    for (int k = 0; k < 3; k++) begin
      if (general) begin
        s1_prod_nxt[SURF_SLOT][k] = PROD_W'(normal_r[SURF_SLOT][k]) * PROD_W'(eye_v[k]);
      end else if (surf_type == CODE_W'(k)) begin
        s1_prod_nxt[SURF_SLOT][k] = PROD_W'(eye_v[k]) <<< Q_SHIFT;
      end else begin
        s1_prod_nxt[SURF_SLOT][k] = '0;
      end
    end
    s1_base_nxt[SURF_SLOT] = q_item.back
        ? THR_W'(dist_r[SURF_SLOT]) - THR_W'(BACKFACE_MARGIN)
        : THR_W'(dist_r[SURF_SLOT]) + THR_W'(BACKFACE_MARGIN);
  end

  always_comb begin
    for (int l = 0; l < NUM_SLOTS; l++) begin
      s2_dot_nxt[l] = DOT_W'(s1_prod_r[l][0]) + DOT_W'(s1_prod_r[l][1])
                    + DOT_W'(s1_prod_r[l][2]);
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_SLOTS; l++) begin
      thr[l] = $signed({{(DOT_W-THR_W-Q_SHIFT){s2_base_r[l][THR_W-1]}},
                        s2_base_r[l], {Q_SHIFT{1'b0}}});
    end
    for (int i = 0; i < FRUSTUM_PLANES; i++) begin
      hit[i] = s2_ctl_r.mask[i] &&
               ((s2_ctl_r.kind == K_SPHERE) ? (s2_dot_r[i] <= thr[i])
                                            : (s2_dot_r[i] < thr[i]));
    end
    surf_hit = s2_ctl_r.back ? (s2_dot_r[SURF_SLOT] >= thr[SURF_SLOT])
                             : (s2_dot_r[SURF_SLOT] <= thr[SURF_SLOT]);
    case (s2_ctl_r.kind)
      K_BOX, K_SPHERE: out_culled_nxt = |hit;
      K_SURF:          out_culled_nxt = surf_hit || (|hit);
      default:         out_culled_nxt = 1'b0;
    endcase
    out_valid_nxt = adv ? s2_valid_r : out_valid_r;
  end

  // plane loads take effect as the load leaves the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        for (int k = 0; k < 3; k++) begin
          normal_r[s][k] <= '0;
        end
        dist_r[s] <= '0;
        code_r[s] <= '0;
      end
    end else if (pop && q_item.kind == K_LOAD) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (q_item.slot == SLOT_W'(s)) begin
          normal_r[s][0] <= q_item.a.x[NORMAL_W-1:0];
          normal_r[s][1] <= q_item.a.y[NORMAL_W-1:0];
          normal_r[s][2] <= q_item.a.z[NORMAL_W-1:0];
          dist_r[s]      <= q_item.scalar;
          code_r[s]      <= q_item.code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= q_valid;
        s2_valid_r <= s1_valid_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r.kind <= q_item.kind;
      s1_ctl_r.mask <= q_item.mask;
      s1_ctl_r.back <= q_item.back;
      s1_prod_r     <= s1_prod_nxt;
      s1_base_r     <= s1_base_nxt;
      s2_ctl_r      <= s1_ctl_r;
      s2_dot_r      <= s2_dot_nxt;
      s2_base_r     <= s1_base_r;
      out_culled_r  <= out_culled_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_culled = out_culled_r;

endmodule

[rtl/core/frustum_box_sphere_surface_cull_core.sv]
// top level: config registers, front end, queue and back end of the cull core
// throughput: one transaction per cycle unless out_stall holds a valid result; all five plane
// lanes run side by side, each through a multiply stage, a sum stage and a compare into
// the result register
// reset: clears handshake state, zeroes the plane bank and the config registers
module frustum_box_sphere_surface_cull_core import fbsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic [MASK_W-1:0]         in_clip_mask,
  input  logic [CODE_W-1:0]         in_plane_code,
  input  logic                      in_back_side,
  input  logic signed [COORD_W-1:0] in_a_x,
  input  logic signed [COORD_W-1:0] in_a_y,
  input  logic signed [COORD_W-1:0] in_a_z,
  input  logic signed [COORD_W-1:0] in_b_x,
  input  logic signed [COORD_W-1:0] in_b_y,
  input  logic signed [COORD_W-1:0] in_b_z,
  input  logic signed [COORD_W-1:0] in_scalar,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_culled,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  output logic [CFG_DATA_W-1:0]     prdata,
  output logic                      pready
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_valid;
  item_t head_item;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_CULL_DISABLE: cfg_nxt.cull_disable = pwdata[0];
        REG_EYE_X:        cfg_nxt.eye.x        = pwdata[COORD_W-1:0];
        REG_EYE_Y:        cfg_nxt.eye.y        = pwdata[COORD_W-1:0];
        REG_EYE_Z:        cfg_nxt.eye.z        = pwdata[COORD_W-1:0];
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CULL_DISABLE: prdata = CFG_DATA_W'(cfg_r.cull_disable);
      REG_EYE_X:        prdata = CFG_DATA_W'(unsigned'(cfg_r.eye.x));
      REG_EYE_Y:        prdata = CFG_DATA_W'(unsigned'(cfg_r.eye.y));
      REG_EYE_Z:        prdata = CFG_DATA_W'(unsigned'(cfg_r.eye.z));
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fbsc_front u_front (
    .cull_disable  (cfg_r.cull_disable),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_slot       (in_slot),
    .in_clip_mask  (in_clip_mask),
    .in_plane_code (in_plane_code),
    .in_back_side  (in_back_side),
    .in_a_x        (in_a_x),
    .in_a_y        (in_a_y),
    .in_a_z        (in_a_z),
    .in_b_x        (in_b_x),
    .in_b_y        (in_b_y),
    .in_b_z        (in_b_z),
    .in_scalar     (in_scalar),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  fbsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head_item (head_item)
  );

  fbsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eye        (cfg_r.eye),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_culled (out_culled)
  );

endmodule

[verif/cull_checker.sv]
// scoreboard for the cull core: tracks the plane bank, predicts each culled bit, checks in order
module cull_checker import fbsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic [MASK_W-1:0]         in_clip_mask,
  input  logic [CODE_W-1:0]         in_plane_code,
  input  logic                      in_back_side,
  input  logic signed [COORD_W-1:0] in_a_x,
  input  logic signed [COORD_W-1:0] in_a_y,
  input  logic signed [COORD_W-1:0] in_a_z,
  input  logic signed [COORD_W-1:0] in_b_x,
  input  logic signed [COORD_W-1:0] in_b_y,
  input  logic signed [COORD_W-1:0] in_b_z,
  input  logic signed [COORD_W-1:0] in_scalar,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_culled,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  input  logic                      pready,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_ONE = longint'(1) << Q_SHIFT;

  logic signed [NORMAL_W-1:0] norm_bank [NUM_SLOTS][3];
  logic signed [31:0]         dist_bank [NUM_SLOTS];
  logic [CODE_W-1:0]          code_bank [NUM_SLOTS];
  logic                       cull_off;
  logic signed [COORD_W-1:0]  eye_x, eye_y, eye_z;
  bit                         culled_q [$];
  bit                         want;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // normal in Q2.16 times integer point gives Q.16, exact in 64 bits
  function automatic longint plane_dot(int s, longint x, longint y, longint z);
    return longint'(norm_bank[s][0]) * x + longint'(norm_bank[s][1]) * y +
           longint'(norm_bank[s][2]) * z;
  endfunction

  function automatic longint dist_q24(int s);
    return longint'(dist_bank[s]) * Q_ONE;
  endfunction

  function automatic bit box_out(coord3_t mn, coord3_t mx, logic [MASK_W-1:0] mask);
    longint px, py, pz;
    bit     hit;
    hit = 1'b0;
    for (int i = 0; i < FRUSTUM_PLANES && i < MASK_W; i++) begin
      if (mask[i]) begin
        // a set sign bit selects the min corner on that axis
        px = code_bank[i][0] ? longint'(mn.x) : longint'(mx.x);
        py = code_bank[i][1] ? longint'(mn.y) : longint'(mx.y);
        pz = code_bank[i][2] ? longint'(mn.z) : longint'(mx.z);
        if (plane_dot(i, px, py, pz) < dist_q24(i)) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic bit sphere_out(coord3_t c, longint r, logic [MASK_W-1:0] mask);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < FRUSTUM_PLANES && i < MASK_W; i++) begin
      if (mask[i] && plane_dot(i, c.x, c.y, c.z) - dist_q24(i) <= -(r * Q_ONE)) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic bit surf_out(coord3_t mn, coord3_t mx, logic [MASK_W-1:0] mask,
                                  logic back);
    longint d, margin, ex, ey, ez;
    logic [CODE_W-1:0] t;
    ex = longint'(eye_x);
    ey = longint'(eye_y);
    ez = longint'(eye_z);
    t  = code_bank[SURF_SLOT];
    if (t < AXIS_COUNT) begin
      // axial plane: distance is the eye coordinate itself, no scaling
      d = ((t == 0) ? ex : (t == 1) ? ey : ez) - longint'(dist_bank[SURF_SLOT]);
      margin = BACKFACE_MARGIN;
    end else begin
      d = plane_dot(SURF_SLOT, ex, ey, ez) - dist_q24(SURF_SLOT);
      margin = longint'(BACKFACE_MARGIN) * Q_ONE;
    end
    if (!back && d <= margin) return 1'b1;
    if (back && d >= -margin) return 1'b1;
    return (mask != 0) && box_out(mn, mx, mask);
  endfunction

  function automatic bit predict_culled(op_t op, logic [SLOT_W-1:0] slot,
                                        logic [MASK_W-1:0] mask, logic back,
                                        logic [CODE_W-1:0] code, coord3_t a, coord3_t b,
                                        logic signed [COORD_W-1:0] sc);
    if (op == OP_LOAD) begin
      if (slot < NUM_SLOTS) begin
        norm_bank[slot][0] = a.x[NORMAL_W-1:0];
        norm_bank[slot][1] = a.y[NORMAL_W-1:0];
        norm_bank[slot][2] = a.z[NORMAL_W-1:0];
        dist_bank[slot]    = 32'(sc);
        code_bank[slot]    = code;
      end
      return 1'b0;
    end
    if (cull_off) return 1'b0;
    case (op)
      OP_BOX:    return box_out(a, b, mask);
      OP_SPHERE: return sphere_out(a, longint'(sc), mask);
      default:   return surf_out(a, b, mask, back);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        for (int k = 0; k < 3; k++) norm_bank[s][k] = '0;
        dist_bank[s] = '0;
        code_bank[s] = '0;
      end
      cull_off = 1'b0;
      eye_x    = '0;
      eye_y    = '0;
      eye_z    = '0;
      culled_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_CULL_DISABLE: cull_off = pwdata[0];
          REG_EYE_X:        eye_x    = pwdata[COORD_W-1:0];
          REG_EYE_Y:        eye_y    = pwdata[COORD_W-1:0];
          REG_EYE_Z:        eye_z    = pwdata[COORD_W-1:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        if (culled_q.size() == 0) begin
          $error("result transaction with nothing expected, culled %0d", out_culled);
          errors++;
        end else begin
          want = culled_q.pop_front();
          if (out_culled !== want) begin
            $error("culled mismatch: expected %0d, actual %0d", want, out_culled);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        culled_q.push_back(predict_culled(op_t'(in_op), in_slot, in_clip_mask, in_back_side,
                                          in_plane_code, {in_a_x, in_a_y, in_a_z},
                                          {in_b_x, in_b_y, in_b_z}, in_scalar));
    end
    pending = culled_q.size();
  end

endmodule

[verif/tb_top.sv]
// testbench top for the cull core: clock, reset, stimulus, register writes and verdict
module tb_top import fbsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [COORD_W-1:0] UNIT_NORMAL = COORD_W'(1 << Q_SHIFT);
  localparam logic signed [COORD_W-1:0] C_MAX       = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN       = 24'sh800000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 126;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE      = 6;

  typedef struct {
    op_t                       op;
    logic [SLOT_W-1:0]         slot;
    logic [MASK_W-1:0]         mask;
    logic [CODE_W-1:0]         code;
    logic                      back;
    coord3_t                   a;
    coord3_t                   b;
    logic signed [COORD_W-1:0] scalar;
  } cull_req_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_op = '0;
  logic [SLOT_W-1:0]         in_slot = '0;
  logic [MASK_W-1:0]         in_clip_mask = '0;
  logic [CODE_W-1:0]         in_plane_code = '0;
  logic                      in_back_side = 1'b0;
  logic signed [COORD_W-1:0] in_a_x = '0;
  logic signed [COORD_W-1:0] in_a_y = '0;
  logic signed [COORD_W-1:0] in_a_z = '0;
  logic signed [COORD_W-1:0] in_b_x = '0;
  logic signed [COORD_W-1:0] in_b_y = '0;
  logic signed [COORD_W-1:0] in_b_z = '0;
  logic signed [COORD_W-1:0] in_scalar = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_culled;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]     paddr = '0;
  logic [CFG_DATA_W-1:0]     pwdata = '0;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;

  int fail_count;
  int pending;
  int hold_requests = 0;
  int hold_served = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  frustum_box_sphere_surface_cull_core dut (.*);

  cull_checker chk (.errors(fail_count), .pending(pending), .*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stall, calm stretches, and long holds on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= !rx_calm && ($urandom_range(0, 99) < 18);
      end
    end
  end

  function automatic coord3_t pt(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic signed [COORD_W-1:0] z);
    return {x, y, z};
  endfunction

  function automatic cull_req_t mk(op_t op, logic [SLOT_W-1:0] slot, logic [MASK_W-1:0] mask,
                                   logic [CODE_W-1:0] code, logic back, coord3_t a, coord3_t b,
                                   logic signed [COORD_W-1:0] sc);
    cull_req_t r;
    r.op     = op;
    r.slot   = slot;
    r.mask   = mask;
    r.code   = code;
    r.back   = back;
    r.a      = a;
    r.b      = b;
    r.scalar = sc;
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return 0;
          default: return -1;
        endcase
      end
      1, 2, 3, 4: return COORD_W'($urandom);
      default:    return COORD_W'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  // upper bits above the 18-bit normal still toggle through the full random picks
  function automatic logic signed [COORD_W-1:0] rand_normal();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return COORD_W'($urandom);
      4, 5:       return UNIT_NORMAL;
      6:          return -UNIT_NORMAL;
      7:          return 0;
      default:    return COORD_W'(int'($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  function automatic cull_req_t rand_req();
    cull_req_t                 r;
    logic signed [COORD_W-1:0] t;
    int                        w;
    w = $urandom_range(0, 99);
    r.op   = (w < 20) ? OP_LOAD : (w < 48) ? OP_BOX : (w < 72) ? OP_SPHERE : OP_SURF;
    r.mask = MASK_W'($urandom_range(0, 15));
    r.code = CODE_W'($urandom_range(0, 7));
    r.back = 1'($urandom_range(0, 1));
    r.b    = pt(rand_coord(), rand_coord(), rand_coord());
    r.scalar = rand_coord();
    if (r.op == OP_LOAD) begin
      r.slot = SLOT_W'(($urandom_range(0, 11) != 0) ? $urandom_range(0, NUM_SLOTS - 1)
                                                    : $urandom_range(NUM_SLOTS, 7));
      r.a = pt(rand_normal(), rand_normal(), rand_normal());
    end else begin
      r.slot = SLOT_W'($urandom_range(0, 7));
      r.a = pt(rand_coord(), rand_coord(), rand_coord());
      // mostly ordered boxes, some left with min above max
      if ($urandom_range(0, 3) != 0) begin
        if (r.a.x > r.b.x) begin t = r.a.x; r.a.x = r.b.x; r.b.x = t; end
        if (r.a.y > r.b.y) begin t = r.a.y; r.a.y = r.b.y; r.b.y = t; end
        if (r.a.z > r.b.z) begin t = r.a.z; r.a.z = r.b.z; r.b.z = t; end
      end
      if (r.op == OP_SPHERE && r.scalar < 0 && $urandom_range(0, 4) != 0)
        r.scalar = -r.scalar;
    end
    return r;
  endfunction

  task automatic send(input cull_req_t r);
    while (!tx_calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= r.op;
    in_slot       <= r.slot;
    in_clip_mask  <= r.mask;
    in_plane_code <= r.code;
    in_back_side  <= r.back;
    in_a_x        <= r.a.x;
    in_a_y        <= r.a.y;
    in_a_z        <= r.a.z;
    in_b_x        <= r.b.x;
    in_b_y        <= r.b.y;
    in_b_z        <= r.b.z;
    in_scalar     <= r.scalar;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // back-to-back register writes: setup then access, psel held between them
  task automatic set_config(input logic off, input logic signed [COORD_W-1:0] ex,
                            input logic signed [COORD_W-1:0] ey,
                            input logic signed [COORD_W-1:0] ez);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[REG_CULL_DISABLE] = {31'd0, off};
    vals[REG_EYE_X]        = CFG_DATA_W'(ex);
    vals[REG_EYE_Y]        = CFG_DATA_W'(ey);
    vals[REG_EYE_Z]        = CFG_DATA_W'(ez);
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_t'(i), 2'b00};
      pwdata  <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plane bank: unit x, negated unit y, 18-bit extremes, zero normal, axial surface, out-of-range slot
    send(mk(OP_LOAD, 0, 0, 0, 0, pt(UNIT_NORMAL, 0, 0), pt(0, 0, 0), 100));
    send(mk(OP_LOAD, 1, 0, 7, 0, pt(0, -UNIT_NORMAL, 0), pt(C_MAX, C_MAX, C_MAX), -200));
    send(mk(OP_LOAD, 2, 15, 5, 1, pt(24'h020000, -1, 24'h01FFFF), pt(C_MIN, C_MIN, C_MIN),
            C_MAX));
    send(mk(OP_LOAD, 3, 0, 2, 0, pt(0, 0, 0), pt(0, 0, 0), C_MIN));
    send(mk(OP_LOAD, SURF_SLOT, 0, 0, 0, pt(UNIT_NORMAL, 0, 0), pt(0, 0, 0), 50));
    send(mk(OP_LOAD, 6, 15, 7, 1, pt(-1, -1, -1), pt(-1, -1, -1), -1));
    // box: on the plane, just below it, plane masked off, min above max, extremes
    send(mk(OP_BOX, 0, 4'b0001, 0, 0, pt(0, 0, 0), pt(100, 0, 0), 0));
    send(mk(OP_BOX, 0, 4'b0001, 0, 0, pt(0, 0, 0), pt(99, 0, 0), 0));
    send(mk(OP_BOX, 0, 4'b0000, 0, 0, pt(0, 0, 0), pt(99, 0, 0), 0));
    send(mk(OP_BOX, 0, 4'b0010, 0, 0, pt(0, 201, 0), pt(0, -5, 0), 0));
    send(mk(OP_BOX, 0, 4'b0010, 0, 0, pt(0, 200, 0), pt(0, 300, 0), 0));
    send(mk(OP_BOX, 7, 4'b0100, 7, 1, pt(C_MIN, C_MIN, C_MIN), pt(C_MAX, C_MAX, C_MAX),
            C_MAX));
    send(mk(OP_BOX, 0, 4'b1000, 0, 0, pt(C_MIN, C_MIN, C_MIN), pt(C_MIN, C_MIN, C_MIN), 0));
    // sphere: touching, just outside, negative radius, extremes on all planes
    send(mk(OP_SPHERE, 0, 4'b0001, 0, 0, pt(90, 0, 0), pt(0, 0, 0), 10));
    send(mk(OP_SPHERE, 0, 4'b0001, 0, 0, pt(90, 0, 0), pt(0, 0, 0), 9));
    send(mk(OP_SPHERE, 0, 4'b0001, 0, 0, pt(104, 0, 0), pt(0, 0, 0), -5));
    send(mk(OP_SPHERE, 0, 4'b1111, 0, 0, pt(C_MAX, C_MAX, C_MAX), pt(0, 0, 0), C_MIN));
    // surface, axial x plane: front faces away, back passes, back then box culls
    send(mk(OP_SURF, 0, 4'b0000, 0, 0, pt(0, 0, 0), pt(99, 0, 0), 0));
    send(mk(OP_SURF, 0, 4'b0000, 0, 1, pt(0, 0, 0), pt(99, 0, 0), 0));
    send(mk(OP_SURF, 0, 4'b0001, 0, 1, pt(0, 0, 0), pt(99, 0, 0), 0));
    // general surface plane with the eye exactly at the margin, then a zero normal past it
    send(mk(OP_LOAD, SURF_SLOT, 0, 7, 0, pt(UNIT_NORMAL, 0, 0), pt(0, 0, 0), -3));
    send(mk(OP_SURF, 0, 4'b0000, 0, 0, pt(0, 0, 0), pt(0, 0, 0), 0));
    send(mk(OP_SURF, 0, 4'b0000, 0, 1, pt(0, 0, 0), pt(0, 0, 0), 0));
    send(mk(OP_LOAD, SURF_SLOT, 0, 3, 0, pt(0, 0, 0), pt(0, 0, 0), -4));
    send(mk(OP_SURF, 0, 4'b0000, 0, 0, pt(0, 0, 0), pt(0, 0, 0), 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       set_config(1'b0, rand_coord(), rand_coord(), rand_coord());
        1:       set_config(1'b0, C_MAX, C_MIN, C_MAX);
        2:       set_config(1'b1, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        3:       set_config(1'b0, C_MIN, C_MAX, C_MIN);
        default: set_config(1'b0, rand_coord(), rand_coord(), rand_coord());
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold while the sender keeps offering, so the core backs up
        if (ph == 1 && n == 40) hold_requests++;
        tx_calm = (ph == 1 && n >= 40 && n < 75) || (ph == 3 && n < 70);
        rx_calm = (ph == 3 && n < 70);
        if (ph == 2 && n == 60) wait_idle();
        send(rand_req());
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    wait_idle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fbsc_pkg.sv
rtl/core/fbsc_front.sv
rtl/core/fbsc_queue.sv
rtl/core/fbsc_back.sv
rtl/core/frustum_box_sphere_surface_cull_core.sv
verif/cull_checker.sv
verif/tb_top.sv
